### design/nnfm_pkg.sv
// Shared types and constants of the nearest-neighbor feature matcher.
package nnfm_pkg;

  // Feature and result field widths
  localparam int FEAT_W = 24;
  localparam int NFEAT  = 9;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int DIST_W = 52;
  localparam int SQ_W   = 2 * (FEAT_W + 1);

  // Request action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic signed [FEAT_W-1:0] feat_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [DIST_W-1:0]        dist_t;

  typedef struct packed {
    logic  action;
    idx_t  entry_index;
    feat_t pos_x;
    feat_t pos_y;
    feat_t box_width;
    feat_t box_height;
    feat_t box_angle;
    feat_t axis_x;
    feat_t axis_y;
    feat_t fill_ratio;
    feat_t aspect_ratio;
  } query_req_t;

  typedef struct packed {
    logic  match_found;
    idx_t  best_index;
    dist_t best_distance_sq;
  } match_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load_we;
    logic query_start;
    logic scan_step;
    logic result_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cfg_empty;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

### design/nnfm_chan_if.sv
// Valid/ready channel carrying one payload of a chosen type.
interface nnfm_chan_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/nnfm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nnfm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

### design/nnfm_ctrl.sv
// Sequencing state machine: accept requests, run the scan, hand off the result.
module nnfm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_action,
  output logic                   in_ready,
  input  nnfm_pkg::dp_status_t   status,
  output nnfm_pkg::ctrl_cmd_t    cmd
);
  import nnfm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Decode commands
  always_comb begin
    cmd             = '0;
    cmd.load_we     = in_fire && (in_action == ACT_LOAD);
    cmd.query_start = in_fire && (in_action == ACT_QUERY);
    cmd.scan_step   = (state_r == ST_SCAN);
    cmd.result_load = (state_r == ST_FINISH) && !status.pipe_busy && status.out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.query_start) begin
          state_nxt = status.cfg_empty ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (cmd.result_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

### design/nnfm_dpath.sv
// Datapath: reference tables, squared-distance pipeline, best tracker, result register.
module nnfm_dpath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  nnfm_pkg::ctrl_cmd_t    cmd,
  output nnfm_pkg::dp_status_t   status,
  input  nnfm_pkg::query_req_t   in_req,
  input  logic                   cfg_we,
  input  nnfm_pkg::count_t       cfg_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output nnfm_pkg::match_rsp_t   out_rsp
);
  import nnfm_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LEN_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PIPE_N = 6;

  count_t            cfg_count_r;
  logic [LEN_W-1:0]  scan_len_r;
  logic [LEN_W-1:0]  scan_len_nxt;
  logic [LEN_W-1:0]  scan_cnt_r;
  feat_t             query_r [NFEAT];
  feat_t             wr_feat [NFEAT];
  feat_t             rd_feat [NFEAT];
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;

  logic [PIPE_N-1:0] vld_r;
  idx_t              idx_r [PIPE_N];

  logic signed [FEAT_W:0] diff_w [NFEAT];
  logic [FEAT_W:0]        abs_w  [NFEAT];
  logic [SQ_W-1:0]        sq_r   [NFEAT];
  dist_t                  sum1_r [5];
  dist_t                  sum2_r [3];
  dist_t                  sum3_r [2];
  dist_t                  total_r;

  logic   best_found_r;
  idx_t   best_idx_r;
  dist_t  best_dist_r;
  logic   best_take;

  logic       out_valid_r;
  match_rsp_t out_rsp_r;

  // Unpack the request features in table order
  assign wr_feat[0] = in_req.pos_x;
  assign wr_feat[1] = in_req.pos_y;
  assign wr_feat[2] = in_req.box_width;
  assign wr_feat[3] = in_req.box_height;
  assign wr_feat[4] = in_req.box_angle;
  assign wr_feat[5] = in_req.axis_x;
  assign wr_feat[6] = in_req.axis_y;
  assign wr_feat[7] = in_req.fill_ratio;
  assign wr_feat[8] = in_req.aspect_ratio;

  // Drop loads to slots past the table
  assign ram_we    = cmd.load_we && (32'(in_req.entry_index) < 32'(TABLE_DEPTH));
  assign ram_waddr = ADDR_W'(in_req.entry_index);

  // One table per feature
  for (genvar f = 0; f < NFEAT; f++) begin : g_tab
    nnfm_ram #(
      .WIDTH (FEAT_W),
      .DEPTH (TABLE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_feat[f]),
      .re    (cmd.scan_step),
      .raddr (scan_cnt_r[ADDR_W-1:0]),
      .rdata (rd_feat[f])
    );
  end

  // Clamp the scan length to the table depth
  always_comb begin
    if (32'(cfg_count_r) > 32'(TABLE_DEPTH)) begin
      scan_len_nxt = LEN_W'(TABLE_DEPTH);
    end else begin
      scan_len_nxt = LEN_W'(cfg_count_r);
    end
  end

  // Config register, scan counter, pipeline valids, result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= '0;
      scan_len_r  <= '0;
      scan_cnt_r  <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_count_r <= cfg_data;
      end
      if (cmd.query_start) begin
        scan_len_r <= scan_len_nxt;
        scan_cnt_r <= '0;
      end else if (cmd.scan_step) begin
        scan_cnt_r <= scan_cnt_r + LEN_W'(1);
      end
      vld_r <= {vld_r[PIPE_N-2:0], cmd.scan_step};
      if (cmd.result_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the query features
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      for (int f = 0; f < NFEAT; f++) begin
        query_r[f] <= wr_feat[f];
      end
    end
  end

  // Carry the slot number down the pipeline
  always_ff @(posedge clk) begin
    idx_r[0] <= idx_t'(scan_cnt_r);
    for (int s = 1; s < PIPE_N; s++) begin
      idx_r[s] <= idx_r[s-1];
    end
  end

  // Per-feature absolute difference
  always_comb begin
    for (int f = 0; f < NFEAT; f++) begin
      diff_w[f] = (FEAT_W+1)'(query_r[f]) - (FEAT_W+1)'(rd_feat[f]);
      abs_w[f]  = diff_w[f][FEAT_W] ? (FEAT_W+1)'(-diff_w[f]) : (FEAT_W+1)'(diff_w[f]);
    end
  end

  // Square, then reduce through a registered adder tree. Nine squares of at
  // most 2^48 each never reach the 52-bit limit, so no clamping is needed.
  always_ff @(posedge clk) begin
    for (int f = 0; f < NFEAT; f++) begin
      sq_r[f] <= abs_w[f] * abs_w[f];
    end
    for (int k = 0; k < 4; k++) begin
      sum1_r[k] <= DIST_W'(sq_r[2*k]) + DIST_W'(sq_r[2*k+1]);
    end
    sum1_r[4] <= DIST_W'(sq_r[8]);
    sum2_r[0] <= sum1_r[0] + sum1_r[1];
    sum2_r[1] <= sum1_r[2] + sum1_r[3];
    sum2_r[2] <= sum1_r[4];
    sum3_r[0] <= sum2_r[0] + sum2_r[1];
    sum3_r[1] <= sum2_r[2];
    total_r   <= sum3_r[0] + sum3_r[1];
  end

  // Keep the first strictly smaller distance
  assign best_take = vld_r[PIPE_N-1] && (!best_found_r || (total_r < best_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (cmd.query_start) begin
      best_found_r <= 1'b0;
    end else if (best_take) begin
      best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      best_idx_r  <= '0;
      best_dist_r <= '0;
    end else if (best_take) begin
      best_idx_r  <= idx_r[PIPE_N-1];
      best_dist_r <= total_r;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_rsp_r.match_found      <= best_found_r;
      out_rsp_r.best_index       <= best_idx_r;
      out_rsp_r.best_distance_sq <= best_dist_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Status to the controller
  always_comb begin
    status           = '0;
    status.cfg_empty = (cfg_count_r == '0);
    status.scan_last = (scan_cnt_r == (scan_len_r - LEN_W'(1)));
    status.pipe_busy = |vld_r;
    status.out_free  = !out_valid_r || out_ready;
  end
endmodule

### design/nearest_neighbor_feature_match_top.sv
// Top level of the nearest-neighbor feature matcher.
//
// Channels: in_ch takes requests. A load request (action 0) writes its nine
// features into slot entry_index and produces no result.
// A query request (action 1) scans slots 0 .. N-1, N being entries_in_use
// clamped to TABLE_DEPTH, and produces one result on out_ch: match_found,
// the first slot with the smallest sum of squared differences, and that sum.
// cfg_ch writes entries_in_use; it is always ready and may be written only
// while no query is in flight.
// Pipeline: during a query scan one table entry enters the distance pipeline
// per cycle; the registered table read feeds five pipeline registers and the
// best-entry register. in_ch stays not ready while a query runs, so the next
// query is accepted only once the previous one has loaded its result.
// Stall: the result waits in the output register; loads are taken meanwhile,
// and a following query finishes its scan and holds its result until the
// register is free.
// Reset: entries_in_use returns to 0 and the channels go idle; table contents
// are not cleared, so slots must be loaded before a query scans them.
module nearest_neighbor_feature_match_top #(
  parameter int TABLE_DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  nnfm_chan_if.sink   in_ch,
  nnfm_chan_if.source out_ch,
  nnfm_chan_if.sink   cfg_ch
);
  import nnfm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  match_rsp_t out_rsp;

  nnfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.data.action),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  nnfm_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_req    (in_ch.data),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  // Drive the channel handshakes
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_rsp;
endmodule

### test/nnfm_match_checker.sv
// Scoreboard for the feature matcher: mirrors the reference table and checks every query result.
module nnfm_match_checker
  import nnfm_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  nnfm_chan_if        in_mon,
  nnfm_chan_if        out_mon,
  nnfm_chan_if        cfg_mon,
  output int unsigned mismatch_count,
  output int unsigned pending_results
);

  typedef logic [NFEAT-1:0][FEAT_W-1:0] feat_vec_t;

  feat_vec_t   stored_vecs [TABLE_DEPTH];
  count_t      scan_count;
  match_rsp_t  expected_matches [$];
  int unsigned fails = 0;

  // Gather the nine features of a request in table order
  function automatic feat_vec_t req_features(query_req_t r);
    feat_vec_t v;
    v[0] = r.pos_x;
    v[1] = r.pos_y;
    v[2] = r.box_width;
    v[3] = r.box_height;
    v[4] = r.box_angle;
    v[5] = r.axis_x;
    v[6] = r.axis_y;
    v[7] = r.fill_ratio;
    v[8] = r.aspect_ratio;
    return v;
  endfunction

  // Scan the active slots for the smallest sum of squared differences.
  // At 24-bit features the sum stays below 2^52, so no clamp is needed.
  function automatic match_rsp_t nearest_entry(feat_vec_t q);
    match_rsp_t best;
    int         n;
    longint     diff;
    longint     sum;
    best = '0;
    n = (int'(scan_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_count);
    for (int i = 0; i < n; i++) begin
      sum = 0;
      for (int f = 0; f < NFEAT; f++) begin
        diff = longint'(feat_t'(q[f])) - longint'(feat_t'(stored_vecs[i][f]));
        sum += diff * diff;
      end
      // strict compare keeps the earlier slot on a tie
      if (!best.match_found || sum < longint'(best.best_distance_sq)) begin
        best.match_found      = 1'b1;
        best.best_index       = idx_t'(i);
        best.best_distance_sq = dist_t'(sum);
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    query_req_t req;
    match_rsp_t got;
    match_rsp_t want;
    if (!rst_n) begin
      scan_count = '0;
      expected_matches.delete();
    end else begin
      // Compare a delivered result against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_matches.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: found=%0d index=%0d dist=%0d",
                     got.match_found, got.best_index, got.best_distance_sq);
        end else begin
          want = expected_matches.pop_front();
          if (got.match_found !== want.match_found ||
              got.best_index !== want.best_index ||
              got.best_distance_sq !== want.best_distance_sq) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp found=%0d idx=%0d dist=%0d, got found=%0d idx=%0d dist=%0d",
                       want.match_found, want.best_index, want.best_distance_sq,
                       got.match_found, got.best_index, got.best_distance_sq);
          end
        end
      end

      // Track the scan count register
      if (cfg_mon.valid && cfg_mon.ready)
        scan_count = cfg_mon.data;

      // Apply a load or predict a query
      if (in_mon.valid && in_mon.ready) begin
        req = in_mon.data;
        if (req.action == ACT_LOAD) begin
          if (int'(req.entry_index) < TABLE_DEPTH)
            stored_vecs[req.entry_index] = req_features(req);
        end else begin
          expected_matches.insert(expected_matches.size(), nearest_entry(req_features(req)));
        end
      end
    end
    mismatch_count  <= fails;
    pending_results <= expected_matches.size();
  end

endmodule

### test/tb_top.sv
// Testbench top for the feature matcher: clock, reset, request stimulus and the verdict.
module tb_top;
  import nnfm_pkg::*;

  localparam int DEPTH          = 64;
  localparam int ITEM_TARGET    = 650;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam feat_t FEAT_MAX    = {1'b0, {(FEAT_W-1){1'b1}}};
  localparam feat_t FEAT_MIN    = {1'b1, {(FEAT_W-1){1'b0}}};

  typedef logic [NFEAT-1:0][FEAT_W-1:0] feat_vec_t;

  logic clk = 1'b0;
  logic rst_n;

  nnfm_chan_if #(.data_t(query_req_t)) in_ch ();
  nnfm_chan_if #(.data_t(match_rsp_t)) out_ch ();
  nnfm_chan_if #(.data_t(count_t))     cfg_ch ();

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned idle_cycles   = 0;
  int unsigned in_gap_pct    = 0;
  int unsigned out_stall_pct = 0;
  int unsigned stall_left    = 0;
  int unsigned items_sent    = 0;
  count_t      scan_count    = '0;
  bit          loaded [DEPTH];
  feat_vec_t   shadow_vecs [DEPTH];

  nearest_neighbor_feature_match_top #(.TABLE_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  nnfm_match_checker #(.TABLE_DEPTH(DEPTH)) match_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_mon         (cfg_ch),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Drop result ready in random bursts
  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left   <= 0;
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      stall_left   <= $urandom_range(1, 14);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Count cycles in which no channel moves anything
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic feat_t clamp_feat(int v);
    if (v > int'(FEAT_MAX)) return FEAT_MAX;
    if (v < int'(FEAT_MIN)) return FEAT_MIN;
    return feat_t'(v);
  endfunction

  function automatic feat_vec_t fill_vec(feat_t v);
    feat_vec_t r;
    for (int f = 0; f < NFEAT; f++) r[f] = v;
    return r;
  endfunction

  // Mix extremes, values near zero and full-range noise per feature
  function automatic feat_vec_t random_vec();
    feat_vec_t r;
    for (int f = 0; f < NFEAT; f++) begin
      case ($urandom_range(0, 7))
        0:       r[f] = FEAT_MAX;
        1:       r[f] = FEAT_MIN;
        2:       r[f] = feat_t'(int'($urandom_range(0, 31)) - 16);
        default: r[f] = feat_t'($urandom);
      endcase
    end
    return r;
  endfunction

  function automatic feat_vec_t nudge_vec(feat_vec_t base, int spread);
    feat_vec_t r;
    int        delta;
    for (int f = 0; f < NFEAT; f++) begin
      delta = int'($urandom_range(0, 2 * spread)) - spread;
      r[f]  = clamp_feat(int'(feat_t'(base[f])) + delta);
    end
    return r;
  endfunction

  function automatic query_req_t make_req(logic action, idx_t idx, feat_vec_t v);
    query_req_t r;
    r.action       = action;
    r.entry_index  = idx;
    r.pos_x        = feat_t'(v[0]);
    r.pos_y        = feat_t'(v[1]);
    r.box_width    = feat_t'(v[2]);
    r.box_height   = feat_t'(v[3]);
    r.box_angle    = feat_t'(v[4]);
    r.axis_x       = feat_t'(v[5]);
    r.axis_y       = feat_t'(v[6]);
    r.fill_ratio   = feat_t'(v[7]);
    r.aspect_ratio = feat_t'(v[8]);
    return r;
  endfunction

  function automatic int active_slots();
    return (int'(scan_count) > DEPTH) ? DEPTH : int'(scan_count);
  endfunction

  // True when every slot a query would scan has been loaded
  function automatic bit scan_covered();
    for (int i = 0; i < active_slots(); i++)
      if (!loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Offer one request, with an optional gap ahead of it; valid stays high on return
  task automatic send_req(query_req_t req);
    int unsigned gap;
    if ($urandom_range(0, 99) < in_gap_pct) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_load(int idx, feat_vec_t v);
    send_req(make_req(ACT_LOAD, idx_t'(idx), v));
    loaded[idx]      = 1'b1;
    shadow_vecs[idx] = v;
  endtask

  task automatic send_query(feat_vec_t v);
    send_req(make_req(ACT_QUERY, idx_t'($urandom), v));
  endtask

  // Hold requests until all results are out and the block is quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic retune(count_t value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    scan_count = value;
  endtask

  // Queries mostly land near a stored entry so the winner moves around
  task automatic random_query();
    int unsigned pick;
    int          n;
    feat_vec_t   v;
    n    = active_slots();
    pick = $urandom_range(0, 99);
    if (n > 0 && pick < 40)
      v = nudge_vec(shadow_vecs[$urandom_range(0, n - 1)], $urandom_range(1, 4096));
    else if (n > 0 && pick < 60)
      v = shadow_vecs[$urandom_range(0, n - 1)];
    else if (pick < 85)
      v = random_vec();
    else
      v = fill_vec($urandom_range(0, 1) ? FEAT_MAX : FEAT_MIN);
    send_query(v);
  endtask

  // Loads build clusters and exact duplicates to force close calls and ties
  task automatic random_load(int idx);
    int unsigned pick;
    int          src;
    feat_vec_t   v;
    pick = $urandom_range(0, 99);
    src  = $urandom_range(0, DEPTH - 1);
    if (pick < 45 || !loaded[src])
      v = random_vec();
    else if (pick < 70)
      v = nudge_vec(shadow_vecs[src], $urandom_range(1, 2048));
    else if (pick < 85)
      v = shadow_vecs[src];
    else
      v = fill_vec($urandom_range(0, 1) ? FEAT_MAX : FEAT_MIN);
    send_load(idx, v);
  endtask

  initial begin
    int        order [DEPTH];
    int        j;
    int        tmp;
    int        phase;
    count_t    value;
    feat_vec_t v;

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: queries with the reset count
    send_query(fill_vec(FEAT_MAX));
    send_query(fill_vec(FEAT_MIN));

    // Seed extremes, a duplicate of slot zero, zeros and an alternating pattern
    send_load(0, fill_vec(FEAT_MAX));
    send_load(1, fill_vec(FEAT_MIN));
    send_load(2, fill_vec(FEAT_MAX));
    send_load(3, fill_vec('0));
    for (int f = 0; f < NFEAT; f++)
      v[f] = (f % 2 == 0) ? 24'h555555 : 24'hAAAAAA;
    send_load(63, v);

    // Largest possible distance with a single slot
    retune(1);
    send_query(fill_vec(FEAT_MIN));

    // Ties, exact hits and mixed extremes over four slots
    retune(4);
    send_query(fill_vec(FEAT_MAX));
    send_query(fill_vec(FEAT_MIN));
    send_query(fill_vec('0));
    send_query(fill_vec('1));
    for (int f = 0; f < NFEAT; f++)
      v[f] = (f < 4) ? FEAT_MAX : FEAT_MIN;
    send_query(v);
    send_query(random_vec());
    send_load(4, random_vec());
    send_query(nudge_vec(shadow_vecs[3], 100));

    // Fill every slot in shuffled order, interleaving queries
    in_gap_pct    = 8;
    out_stall_pct = 25;
    for (int k = 0; k < DEPTH; k++) order[k] = k;
    for (int k = DEPTH - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < DEPTH; k++) begin
      random_load(order[k]);
      if ($urandom_range(0, 2) == 0 && scan_covered())
        random_query();
    end

    // Phases with a fresh scan count each, extremes first
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: value = 7'd64;
        1: value = 7'd127;
        2: value = 7'd0;
        3: value = 7'd1;
        4: value = 7'd65;
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: value = count_t'($urandom_range(1, 16));
            5, 6, 7:       value = count_t'($urandom_range(1, 127));
            8:             value = 7'd64;
            default:       value = 7'd127;
          endcase
        end
      endcase
      retune(value);
      if (items_sent + 80 >= ITEM_TARGET) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       in_gap_pct = 0;
          1:       in_gap_pct = 8;
          default: in_gap_pct = 25;
        endcase
        case ($urandom_range(0, 2))
          0:       out_stall_pct = 0;
          1:       out_stall_pct = 8;
          default: out_stall_pct = 25;
        endcase
      end
      repeat (50) begin
        if ($urandom_range(0, 99) < 65)
          random_query();
        else
          random_load($urandom_range(0, DEPTH - 1));
      end
      phase++;
    end

    drain();
    if (mismatch_count == 0 && pending_results == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
